### hw/rtl/bpc_pkg.sv
package bpc_pkg;

  // Field widths fixed by the pixel format.
  localparam int unsigned ValW   = 8;
  localparam int unsigned CoordW = 15;
  localparam int unsigned SumW   = 12;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);

  // Canvas size after reset.
  localparam logic [CoordW-1:0] CanvasReset = 15'd1024;

  // Blur average: floor(v / 9) for v below 2**16 as (v * BlurRecip) >> BlurShift.
  localparam logic [15:0] BlurRecip = 16'd58255;
  localparam int unsigned BlurShift = 19;

  // Drawing modes.
  typedef enum logic [2:0] {
    MODE_BLEND     = 3'd0,
    MODE_MAX       = 3'd1,
    MODE_ERASE     = 3'd2,
    MODE_OVERWRITE = 3'd3,
    MODE_BLUR      = 3'd4
  } bpc_mode_e;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_DRAW_MODE     = 3'd0,
    REG_USE_SELECTION = 3'd1,
    REG_USE_MASK      = 3'd2,
    REG_USE_TEXTURE   = 3'd3,
    REG_CANVAS_WIDTH  = 3'd4,
    REG_CANVAS_HEIGHT = 3'd5
  } bpc_reg_e;

  // Live configuration.
  typedef struct packed {
    logic [2:0]        draw_mode;
    logic              use_selection;
    logic              use_mask;
    logic              use_texture;
    logic [CoordW-1:0] canvas_width;
    logic [CoordW-1:0] canvas_height;
  } bpc_cfg_t;

  // One classified pixel as it waits in the queue.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              on_canvas;
    logic              gated;
    logic [ValW-1:0]   limit;
    logic [ValW-1:0]   brush;
    logic [ValW-1:0]   dest;
    logic [ValW-1:0]   blur;
    logic              new_stroke;
  } bpc_item_t;

  // floor(v / 255), exact for v up to 65279, where the quotient still fits in 8 bits.
  function automatic logic [ValW-1:0] div255(logic [15:0] v);
    logic [16:0] s;
    s = 17'(v) + 17'(v[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

### hw/rtl/bpc_front.sv
module bpc_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [15:0]        pixel_x_i,
  input  logic signed [15:0]        pixel_y_i,
  input  logic [7:0]                brush_value_i,
  input  logic [7:0]                dest_value_i,
  input  logic [7:0]                selection_value_i,
  input  logic [7:0]                mask_value_i,
  input  logic [7:0]                texture_value_i,
  input  logic [11:0]               neighbour_sum_i,
  input  logic                      new_stroke_i,
  input  bpc_pkg::bpc_cfg_t         cfg_i,
  input  logic                      full_i,
  output logic                      push_o,
  output bpc_pkg::bpc_item_t        item_o
);
  import bpc_pkg::*;

  logic              x_neg, y_neg;
  logic [CoordW-1:0] x_mag, y_mag;
  logic [15:0]       tex_prod;
  logic [15:0]       blur_scaled;
  logic [31:0]       blur_prod;
  logic [8:0]        blur_avg;

  // The queue takes a beat whenever it has room.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Coordinates: the low COORD_BITS bits form a two's complement value.
  assign x_neg = pixel_x_i[COORD_BITS-1];
  assign y_neg = pixel_y_i[COORD_BITS-1];
  assign x_mag = CoordW'(pixel_x_i[COORD_BITS-2:0]);
  assign y_mag = CoordW'(pixel_y_i[COORD_BITS-2:0]);

  // Texture scaling of the brush, rounded: (v * t + 127) / 255.
  assign tex_prod = 16'(brush_value_i) * 16'(texture_value_i) + 16'd127;

  // Blur average of the neighborhood, formed in steps of 1/16 and rounded to the nearest integer.
  assign blur_scaled = {neighbour_sum_i, 4'b0000};
  assign blur_prod   = 32'(blur_scaled) * 32'(BlurRecip);
  assign blur_avg    = 9'((13'(blur_prod[31:BlurShift]) + 13'd8) >> 4);

  // Classification of the pixel.
  always_comb begin
    item_o.x          = x_mag;
    item_o.y          = y_mag;
    item_o.on_canvas  = !x_neg && !y_neg &&
                        (x_mag < cfg_i.canvas_width) && (y_mag < cfg_i.canvas_height);
    item_o.gated      = (cfg_i.use_selection && (selection_value_i == '0)) ||
                        (cfg_i.use_mask && (mask_value_i == '0));
    item_o.limit      = cfg_i.use_mask ? mask_value_i : 8'hff;
    item_o.brush      = cfg_i.use_texture ? div255(tex_prod) : brush_value_i;
    item_o.dest       = dest_value_i;
    item_o.blur       = blur_avg[8] ? 8'hff : blur_avg[7:0];
    item_o.new_stroke = new_stroke_i;
  end

endmodule

### hw/rtl/bpc_queue.sv
module bpc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bpc_pkg::bpc_item_t item_i,
  input  logic               pop_i,
  output bpc_pkg::bpc_item_t item_o,
  output logic               empty_o,
  output logic               full_o
);
  import bpc_pkg::*;

  bpc_item_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### hw/rtl/bpc_back.sv
module bpc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpc_pkg::bpc_cfg_t  cfg_i,
  input  bpc_pkg::bpc_item_t item_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               write_enable_o,
  output logic [7:0]         new_value_o,
  output logic               rect_valid_o,
  output logic [14:0]        rect_left_o,
  output logic [14:0]        rect_top_o,
  output logic [14:0]        rect_right_o,
  output logic [14:0]        rect_bottom_o
);
  import bpc_pkg::*;

  typedef struct packed {
    bpc_item_t   item;
    logic [15:0] prod;
  } stage_a_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              on_canvas;
    logic              gated;
    logic [ValW-1:0]   res;
    logic [ValW-1:0]   dest;
    logic              new_stroke;
  } stage_b_t;

  logic     a_valid_q, b_valid_q, out_valid_q;
  stage_a_t a_q, a_d;
  stage_b_t b_q, b_d;
  logic     a_ld, b_ld, out_ld;

  logic [ValW-1:0]   q1, q2, rem;
  logic [12:0]       frac_div;
  logic [14:0]       blend_t;
  logic [ValW-1:0]   blend, mode_res;

  logic              we_q, we_d;
  logic [ValW-1:0]   val_q, val_d;
  logic              dv_q, dv_d;
  logic [CoordW-1:0] dl_q, dl_d, dt_q, dt_d, dr_q, dr_d, db_q, db_d;

  // Stage advance: each stage loads when the one after it has room.
  assign out_ld = b_valid_q && (!out_valid_q || !out_stall_i);
  assign b_ld   = a_valid_q && (!b_valid_q || out_ld);
  assign a_ld   = !empty_i && (!a_valid_q || b_ld);
  assign pop_o  = a_ld;

  // Stage A: brush times destination for the blend.
  always_comb begin
    a_d.item = item_i;
    a_d.prod = 16'(item_i.brush) * 16'(item_i.dest);
  end

  // Stage B: blend division by 255 in two parts, floor(32p/255) = 32q + floor(32r/255).
  always_comb begin
    q1       = div255(a_q.prod);
    rem      = 8'(a_q.prod - {q1, 8'h00} + 16'(q1));
    q2       = div255(16'({rem, 5'b00000}));
    frac_div = {q1, 5'b00000} + 13'(q2);
    blend_t  = ((15'(a_q.item.brush) + 15'(a_q.item.dest)) << 5) - 15'(frac_div) + 15'd16;
    blend    = blend_t[12:5];
  end

  // Stage B: mode selection and the clamp to the limit.
  always_comb begin
    case (bpc_mode_e'(cfg_i.draw_mode))
      MODE_BLEND: begin
        mode_res = blend;
      end
      MODE_MAX: begin
        mode_res = (a_q.item.brush > a_q.item.dest) ? a_q.item.brush : a_q.item.dest;
      end
      MODE_ERASE: begin
        mode_res = (a_q.item.dest > a_q.item.brush) ? a_q.item.dest - a_q.item.brush : '0;
      end
      MODE_OVERWRITE: begin
        mode_res = a_q.item.brush;
      end
      MODE_BLUR: begin
        mode_res = (a_q.item.brush != '0) ? a_q.item.blur : a_q.item.dest;
      end
      default: begin
        mode_res = a_q.item.dest;
      end
    endcase
    b_d.res        = (mode_res > a_q.item.limit) ? a_q.item.limit : mode_res;
    b_d.x          = a_q.item.x;
    b_d.y          = a_q.item.y;
    b_d.on_canvas  = a_q.item.on_canvas;
    b_d.gated      = a_q.item.gated;
    b_d.dest       = a_q.item.dest;
    b_d.new_stroke = a_q.item.new_stroke;
  end

  // Output stage: write decision and the dirty rectangle.
  always_comb begin
    we_d  = !b_q.gated && b_q.on_canvas && (b_q.res != b_q.dest);
    val_d = we_d ? b_q.res : b_q.dest;
    if (b_q.new_stroke) begin
      dv_d = 1'b0;
      dl_d = '0;
      dt_d = '0;
      dr_d = '0;
      db_d = '0;
    end else begin
      dv_d = dv_q;
      dl_d = dl_q;
      dt_d = dt_q;
      dr_d = dr_q;
      db_d = db_q;
    end
    if (we_d) begin
      if (dv_d) begin
        dl_d = (b_q.x < dl_d) ? b_q.x : dl_d;
        dt_d = (b_q.y < dt_d) ? b_q.y : dt_d;
        dr_d = (b_q.x > dr_d) ? b_q.x : dr_d;
        db_d = (b_q.y > db_d) ? b_q.y : db_d;
      end else begin
        dl_d = b_q.x;
        dr_d = b_q.x;
        dt_d = b_q.y;
        db_d = b_q.y;
      end
      dv_d = 1'b1;
    end
  end

  // Control and rectangle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      dv_q        <= 1'b0;
      dl_q        <= '0;
      dt_q        <= '0;
      dr_q        <= '0;
      db_q        <= '0;
    end else begin
      a_valid_q   <= a_ld || (a_valid_q && !b_ld);
      b_valid_q   <= b_ld || (b_valid_q && !out_ld);
      out_valid_q <= out_ld || (out_valid_q && out_stall_i);
      if (out_ld) begin
        dv_q <= dv_d;
        dl_q <= dl_d;
        dt_q <= dt_d;
        dr_q <= dr_d;
        db_q <= db_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (a_ld) begin
      a_q <= a_d;
    end
    if (b_ld) begin
      b_q <= b_d;
    end
    if (out_ld) begin
      we_q  <= we_d;
      val_q <= val_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign new_value_o    = val_q;
  assign rect_valid_o   = dv_q;
  assign rect_left_o    = dl_q;
  assign rect_top_o     = dt_q;
  assign rect_right_o   = dr_q;
  assign rect_bottom_o  = db_q;

endmodule

### hw/rtl/brush_pixel_composite_top.sv
// An accepted input beat passes through a queue entry and the stage A, stage B and output registers.
// Throughput: one pixel per cycle while out_stall_i is low; the dirty rectangle is updated in the output stage.
// A four-entry queue separates the classifying front from the three-stage back.
// Reset (rst_ni low, asynchronous) empties the queue and the stages, clears the
// dirty rectangle, and sets draw_mode and the enables to 0 and the canvas to 1024x1024.
module brush_pixel_composite_top #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] pixel_x_i,
  input  logic signed [15:0] pixel_y_i,
  input  logic [7:0]         brush_value_i,
  input  logic [7:0]         dest_value_i,
  input  logic [7:0]         selection_value_i,
  input  logic [7:0]         mask_value_i,
  input  logic [7:0]         texture_value_i,
  input  logic [11:0]        neighbour_sum_i,
  input  logic               new_stroke_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               write_enable_o,
  output logic [7:0]         new_value_o,
  output logic               rect_valid_o,
  output logic [14:0]        rect_left_o,
  output logic [14:0]        rect_top_o,
  output logic [14:0]        rect_right_o,
  output logic [14:0]        rect_bottom_o
);
  import bpc_pkg::*;

  bpc_cfg_t  cfg_q, cfg_d;
  bpc_reg_e  reg_idx;
  logic      cfg_wr;
  logic      push, pop, empty, full;
  bpc_item_t front_item, queue_item;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = bpc_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_DRAW_MODE:     cfg_d.draw_mode     = pwdata[2:0];
        REG_USE_SELECTION: cfg_d.use_selection = pwdata[0];
        REG_USE_MASK:      cfg_d.use_mask      = pwdata[0];
        REG_USE_TEXTURE:   cfg_d.use_texture   = pwdata[0];
        REG_CANVAS_WIDTH:  cfg_d.canvas_width  = pwdata[CoordW-1:0];
        REG_CANVAS_HEIGHT: cfg_d.canvas_height = pwdata[CoordW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.draw_mode     <= '0;
      cfg_q.use_selection <= 1'b0;
      cfg_q.use_mask      <= 1'b0;
      cfg_q.use_texture   <= 1'b0;
      cfg_q.canvas_width  <= CanvasReset;
      cfg_q.canvas_height <= CanvasReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_DRAW_MODE:     prdata = 32'(cfg_q.draw_mode);
      REG_USE_SELECTION: prdata = 32'(cfg_q.use_selection);
      REG_USE_MASK:      prdata = 32'(cfg_q.use_mask);
      REG_USE_TEXTURE:   prdata = 32'(cfg_q.use_texture);
      REG_CANVAS_WIDTH:  prdata = 32'(cfg_q.canvas_width);
      REG_CANVAS_HEIGHT: prdata = 32'(cfg_q.canvas_height);
      default:           prdata = '0;
    endcase
  end

  bpc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .brush_value_i     (brush_value_i),
    .dest_value_i      (dest_value_i),
    .selection_value_i (selection_value_i),
    .mask_value_i      (mask_value_i),
    .texture_value_i   (texture_value_i),
    .neighbour_sum_i   (neighbour_sum_i),
    .new_stroke_i      (new_stroke_i),
    .cfg_i             (cfg_q),
    .full_i            (full),
    .push_o            (push),
    .item_o            (front_item)
  );

  bpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty),
    .full_o  (full)
  );

  bpc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_i         (queue_item),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_enable_o (write_enable_o),
    .new_value_o    (new_value_o),
    .rect_valid_o   (rect_valid_o),
    .rect_left_o    (rect_left_o),
    .rect_top_o     (rect_top_o),
    .rect_right_o   (rect_right_o),
    .rect_bottom_o  (rect_bottom_o)
  );

endmodule

### hw/rtl/bpc_checker.sv
module bpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        write_enable_o,
  input logic [7:0]  new_value_o,
  input logic        rect_valid_o,
  input logic [14:0] rect_left_o,
  input logic [14:0] rect_top_o,
  input logic [14:0] rect_right_o,
  input logic [14:0] rect_bottom_o
);

  // A stalled result beat stays and keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_value_o))
    else $error("stalled result beat changed");

  // A flagged write always comes with a valid dirty rectangle.
  a_write_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |-> rect_valid_o)
    else $error("write without a valid dirty rectangle");

  // A valid rectangle is never inverted.
  a_rect_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid_o |-> (rect_left_o <= rect_right_o) && (rect_top_o <= rect_bottom_o))
    else $error("dirty rectangle inverted");

  // An empty rectangle reads as all zero.
  a_rect_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rect_valid_o |-> (rect_left_o == '0) && (rect_top_o == '0) &&
                      (rect_right_o == '0) && (rect_bottom_o == '0))
    else $error("empty dirty rectangle not cleared");

endmodule

bind brush_pixel_composite_top bpc_checker u_bpc_checker (.*);
